/* hdl/quantum_gate_matrix_generator_unit_macros.svh */
// Assertion macros for the quantum gate matrix generator checker.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef QUANTUM_GATE_MATRIX_GENERATOR_UNIT_MACROS_SVH
`define QUANTUM_GATE_MATRIX_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define QGMG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qgmg assertion failed");

// Next-cycle implication, checked out of reset
`define QGMG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qgmg assertion failed");

`endif

/* hdl/qgmg_pkg.sv */
// Shared types, constants and arithmetic helpers for the gate matrix generator.
// No dependencies; the other RTL modules use this package.
`default_nettype none
package qgmg_pkg;

    localparam int ANGLE_BITS  = 32;
    localparam int COEF_BITS   = 18;
    localparam int QW          = 34;   // internal Q30 value width
    localparam int ZW          = 33;   // CORDIC residual width
    localparam int CORDIC_ITER = 24;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = ((4 + 2 * COEF_BITS + 7) / 8) * 8;
    localparam int SH          = 30 - (COEF_BITS - 2);

    typedef logic [ANGLE_BITS-1:0]       t_phase;
    typedef logic signed [QW-1:0]        t_q;
    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic [5:0]                  t_gate;

    typedef struct packed {
        logic  valid;
        t_gate gate;
    } t_ctl;

    localparam t_q Q_ONE  = t_q'(64'sd1073741824);
    localparam t_q Q_HALF = t_q'(64'sd536870912);
    localparam t_q Q_SQ   = t_q'(64'sd759250125);
    localparam t_q Q_GAIN = t_q'(64'sd652032874);

    // gate codes
    localparam t_gate G_I     = 6'd0;
    localparam t_gate G_H     = 6'd1;
    localparam t_gate G_X     = 6'd2;
    localparam t_gate G_Y     = 6'd3;
    localparam t_gate G_Z     = 6'd4;
    localparam t_gate G_S     = 6'd5;
    localparam t_gate G_SDG   = 6'd6;
    localparam t_gate G_T     = 6'd7;
    localparam t_gate G_TDG   = 6'd8;
    localparam t_gate G_SX    = 6'd9;
    localparam t_gate G_SXDG  = 6'd10;
    localparam t_gate G_V     = 6'd11;
    localparam t_gate G_VDG   = 6'd12;
    localparam t_gate G_U     = 6'd13;
    localparam t_gate G_U2    = 6'd14;
    localparam t_gate G_P     = 6'd15;
    localparam t_gate G_RX    = 6'd16;
    localparam t_gate G_RY    = 6'd17;
    localparam t_gate G_RZ    = 6'd18;
    localparam t_gate G_SWAP  = 6'd19;
    localparam t_gate G_ISW   = 6'd20;
    localparam t_gate G_ISWDG = 6'd21;
    localparam t_gate G_ECR   = 6'd22;
    localparam t_gate G_DCX   = 6'd23;
    localparam t_gate G_PER   = 6'd24;
    localparam t_gate G_PERDG = 6'd25;
    localparam t_gate G_RXX   = 6'd26;
    localparam t_gate G_RYY   = 6'd27;
    localparam t_gate G_RZZ   = 6'd28;
    localparam t_gate G_RZX   = 6'd29;
    localparam t_gate G_XMY   = 6'd30;
    localparam t_gate G_XPY   = 6'd31;
    localparam t_gate G_FIRST_TWO = 6'd19;
    localparam t_gate G_LAST      = 6'd31;

    // arctangent of 2^-i, a full turn being 2^32
    localparam logic [29:0] ATAN_TAB [CORDIC_ITER] = '{
        30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
        30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
        30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051};

    localparam logic signed [QW:0] CF_RND = (SH > 0) ? ((QW+1)'(1) << (SH - 1)) : '0;
    localparam logic signed [QW:0] CF_HI  = ((QW+1)'(1) << (COEF_BITS - 1)) - (QW+1)'(1);
    localparam logic signed [QW:0] CF_LO  = -((QW+1)'(1) << (COEF_BITS - 1));

    // Q30 product back to Q30, halves round up
    function automatic t_q qmul_rnd(input logic signed [63:0] p);
        logic signed [63:0] t;
        begin
            t = (p + 64'sd536870912) >>> 30;
            return t[QW-1:0];
        end
    endfunction

    // round Q30 to the output fraction and saturate
    function automatic t_coef to_coef(input t_q v);
        logic signed [QW:0] t;
        begin
            t = ((QW+1)'(v) + CF_RND) >>> SH;
            if (t > CF_HI) begin
                t = CF_HI;
            end else if (t < CF_LO) begin
                t = CF_LO;
            end
            return t[COEF_BITS-1:0];
        end
    endfunction

    // angle field into a phase: sign-extend, keep ANGLE_BITS
    function automatic t_phase angle_in(input logic [31:0] a);
        return t_phase'($signed(a));
    endfunction

endpackage
`default_nettype wire

/* hdl/qgmg_cordic.sv */
// Pipelined rotation-mode CORDIC, four phases side by side, one iteration a stage.
// Depends on qgmg_pkg.
`default_nettype none
module qgmg_cordic (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire qgmg_pkg::t_ctl    i_ctl,
    input  wire qgmg_pkg::t_phase  i_ph [4],
    output qgmg_pkg::t_ctl         o_ctl,
    output qgmg_pkg::t_q           o_cos [4],
    output qgmg_pkg::t_q           o_sin [4]
);
    import qgmg_pkg::*;

    t_ctl                r_ctl [0:CORDIC_ITER];
    t_q                  r_x   [0:CORDIC_ITER][4];
    t_q                  r_y   [0:CORDIC_ITER][4];
    logic signed [ZW-1:0] r_z  [0:CORDIC_ITER][4];
    logic [1:0]          r_qd  [0:CORDIC_ITER][4];

    t_q                  n_x   [1:CORDIC_ITER][4];
    t_q                  n_y   [1:CORDIC_ITER][4];
    logic signed [ZW-1:0] n_z  [1:CORDIC_ITER][4];
    logic [29:0]         n_r0  [4];

    t_ctl r_octl;
    t_q   r_oc [4];
    t_q   r_os [4];
    t_q   n_oc [4];
    t_q   n_os [4];

    // residual angle scaled to a 2^32 turn
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (ANGLE_BITS >= 32) begin
                n_r0[l] = 30'(i_ph[l][ANGLE_BITS-3:0] >> (ANGLE_BITS - 32));
            end else begin
                n_r0[l] = 30'(i_ph[l][ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
            end
        end
    end

    // one micro-rotation per stage, direction from the residual sign
    always_comb begin
        for (int j = 0; j < CORDIC_ITER; j++) begin
            for (int l = 0; l < 4; l++) begin
                if (!r_z[j][l][ZW-1]) begin
                    n_x[j+1][l] = r_x[j][l] - (r_y[j][l] >>> j);
                    n_y[j+1][l] = r_y[j][l] + (r_x[j][l] >>> j);
                    n_z[j+1][l] = r_z[j][l] - $signed({3'b000, ATAN_TAB[j]});
                end else begin
                    n_x[j+1][l] = r_x[j][l] + (r_y[j][l] >>> j);
                    n_y[j+1][l] = r_y[j][l] - (r_x[j][l] >>> j);
                    n_z[j+1][l] = r_z[j][l] + $signed({3'b000, ATAN_TAB[j]});
                end
            end
        end
    end

    // fold the quadrant back in by swap and negation
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            case (r_qd[CORDIC_ITER][l])
                2'd0: begin
                    n_oc[l] = r_x[CORDIC_ITER][l];
                    n_os[l] = r_y[CORDIC_ITER][l];
                end
                2'd1: begin
                    n_oc[l] = -r_y[CORDIC_ITER][l];
                    n_os[l] = r_x[CORDIC_ITER][l];
                end
                2'd2: begin
                    n_oc[l] = -r_x[CORDIC_ITER][l];
                    n_os[l] = -r_y[CORDIC_ITER][l];
                end
                default: begin
                    n_oc[l] = r_y[CORDIC_ITER][l];
                    n_os[l] = -r_x[CORDIC_ITER][l];
                end
            endcase
        end
    end

    // advance the whole pipe together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= CORDIC_ITER; j++) begin
                r_ctl[j].valid <= 1'b0;
            end
            r_octl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int l = 0; l < 4; l++) begin
                r_x[0][l]  <= Q_GAIN;
                r_y[0][l]  <= '0;
                r_z[0][l]  <= $signed({3'b000, n_r0[l]});
                r_qd[0][l] <= i_ph[l][ANGLE_BITS-1 -: 2];
            end
            for (int j = 1; j <= CORDIC_ITER; j++) begin
                r_ctl[j] <= r_ctl[j-1];
                for (int l = 0; l < 4; l++) begin
                    r_x[j][l]  <= n_x[j][l];
                    r_y[j][l]  <= n_y[j][l];
                    r_z[j][l]  <= n_z[j][l];
                    r_qd[j][l] <= r_qd[j-1][l];
                end
            end
            r_octl <= r_ctl[CORDIC_ITER];
            r_oc   <= n_oc;
            r_os   <= n_os;
        end
    end

    assign o_ctl = r_octl;
    assign o_cos = r_oc;
    assign o_sin = r_os;

endmodule
`default_nettype wire

/* hdl/qgmg_matrix.sv */
// Matrix build: products, per-gate entry placement, rounding to output format.
// Depends on qgmg_pkg.
`default_nettype none
module qgmg_matrix (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire qgmg_pkg::t_ctl  i_ctl,
    input  wire qgmg_pkg::t_q    i_cos [4],
    input  wire qgmg_pkg::t_q    i_sin [4],
    output qgmg_pkg::t_ctl       o_ctl,
    output qgmg_pkg::t_coef      o_re [16],
    output qgmg_pkg::t_coef      o_im [16]
);
    import qgmg_pkg::*;

    // multiply stage
    t_ctl               r_m_ctl;
    logic signed [63:0] r_prod [6];
    t_q                 r_m_ct;
    t_q                 r_m_st;
    t_q                 r_m_c1;
    t_q                 r_m_s1;
    logic signed [31:0] n_k;
    logic signed [31:0] n_k2;

    // placement stage
    t_ctl r_a_ctl;
    t_q   r_a_re [16];
    t_q   r_a_im [16];
    t_q   n_re [16];
    t_q   n_im [16];
    t_q   n_m [6];

    // output stage
    t_ctl  r_c_ctl;
    t_coef r_c_re [16];
    t_coef r_c_im [16];

    // U2 scales by sqrt(2)/2, the others by the theta sine and cosine
    always_comb begin
        n_k  = (i_ctl.gate == G_U2) ? 32'(Q_SQ) : 32'(i_sin[0]);
        n_k2 = (i_ctl.gate == G_U2) ? 32'(Q_SQ) : 32'(i_cos[0]);
    end

    // place entries by gate; unused ones and bad gates stay zero
    always_comb begin
        t_q ct;
        t_q st;
        ct = r_m_ct;
        st = r_m_st;
        for (int i = 0; i < 6; i++) begin
            n_m[i] = qmul_rnd(r_prod[i]);
        end
        for (int k = 0; k < 16; k++) begin
            n_re[k] = '0;
            n_im[k] = '0;
        end
        case (r_m_ctl.gate)
            G_I: begin
                n_re[0] = Q_ONE; n_re[3] = Q_ONE;
            end
            G_H: begin
                n_re[0] = Q_SQ; n_re[1] = Q_SQ; n_re[2] = Q_SQ; n_re[3] = -Q_SQ;
            end
            G_X: begin
                n_re[1] = Q_ONE; n_re[2] = Q_ONE;
            end
            G_Y: begin
                n_im[1] = -Q_ONE; n_im[2] = Q_ONE;
            end
            G_Z: begin
                n_re[0] = Q_ONE; n_re[3] = -Q_ONE;
            end
            G_S: begin
                n_re[0] = Q_ONE; n_im[3] = Q_ONE;
            end
            G_SDG: begin
                n_re[0] = Q_ONE; n_im[3] = -Q_ONE;
            end
            G_T: begin
                n_re[0] = Q_ONE; n_re[3] = Q_SQ; n_im[3] = Q_SQ;
            end
            G_TDG: begin
                n_re[0] = Q_ONE; n_re[3] = Q_SQ; n_im[3] = -Q_SQ;
            end
            G_SX: begin
                n_re[0] = Q_HALF; n_im[0] = Q_HALF; n_re[1] = Q_HALF; n_im[1] = -Q_HALF;
                n_re[2] = Q_HALF; n_im[2] = -Q_HALF; n_re[3] = Q_HALF; n_im[3] = Q_HALF;
            end
            G_SXDG: begin
                n_re[0] = Q_HALF; n_im[0] = -Q_HALF; n_re[1] = Q_HALF; n_im[1] = Q_HALF;
                n_re[2] = Q_HALF; n_im[2] = Q_HALF; n_re[3] = Q_HALF; n_im[3] = -Q_HALF;
            end
            G_V: begin
                n_re[0] = Q_SQ; n_im[1] = -Q_SQ; n_im[2] = -Q_SQ; n_re[3] = Q_SQ;
            end
            G_VDG: begin
                n_re[0] = Q_SQ; n_im[1] = Q_SQ; n_im[2] = Q_SQ; n_re[3] = Q_SQ;
            end
            G_U, G_U2: begin
                n_re[0] = (r_m_ctl.gate == G_U) ? ct : Q_SQ;
                n_re[1] = -n_m[0]; n_im[1] = -n_m[1];
                n_re[2] = n_m[2];  n_im[2] = n_m[3];
                n_re[3] = n_m[4];  n_im[3] = n_m[5];
            end
            G_P: begin
                // the phase factor is the raw lane-one rotation
                n_re[0] = Q_ONE; n_re[3] = r_m_c1; n_im[3] = r_m_s1;
            end
            G_RX: begin
                n_re[0] = ct; n_im[1] = -st; n_im[2] = -st; n_re[3] = ct;
            end
            G_RY: begin
                n_re[0] = ct; n_re[1] = -st; n_re[2] = st; n_re[3] = ct;
            end
            G_RZ: begin
                n_re[0] = ct; n_im[0] = -st; n_re[3] = ct; n_im[3] = st;
            end
            G_SWAP: begin
                n_re[0] = Q_ONE; n_re[6] = Q_ONE; n_re[9] = Q_ONE; n_re[15] = Q_ONE;
            end
            G_ISW: begin
                n_re[0] = Q_ONE; n_im[6] = Q_ONE; n_im[9] = Q_ONE; n_re[15] = Q_ONE;
            end
            G_ISWDG: begin
                n_re[0] = Q_ONE; n_im[6] = -Q_ONE; n_im[9] = -Q_ONE; n_re[15] = Q_ONE;
            end
            G_ECR: begin
                n_re[2] = Q_SQ;  n_im[3] = Q_SQ;  n_im[6] = Q_SQ;   n_re[7] = Q_SQ;
                n_re[8] = Q_SQ;  n_im[9] = -Q_SQ; n_im[12] = -Q_SQ; n_re[13] = Q_SQ;
            end
            G_DCX: begin
                n_re[0] = Q_ONE; n_re[6] = Q_ONE; n_re[11] = Q_ONE; n_re[13] = Q_ONE;
            end
            G_PER: begin
                n_re[3] = Q_ONE; n_re[6] = Q_ONE; n_re[8] = Q_ONE; n_re[13] = Q_ONE;
            end
            G_PERDG: begin
                n_re[2] = Q_ONE; n_re[7] = Q_ONE; n_re[9] = Q_ONE; n_re[12] = Q_ONE;
            end
            G_RXX: begin
                n_re[0] = ct;  n_im[3] = -st;  n_re[5] = ct;  n_im[6] = -st;
                n_im[9] = -st; n_re[10] = ct; n_im[12] = -st; n_re[15] = ct;
            end
            G_RYY: begin
                n_re[0] = ct;  n_im[3] = st;   n_re[5] = ct;  n_im[6] = -st;
                n_im[9] = -st; n_re[10] = ct; n_im[12] = st;  n_re[15] = ct;
            end
            G_RZZ: begin
                n_re[0] = ct;  n_im[0] = -st;  n_re[5] = ct;  n_im[5] = st;
                n_re[10] = ct; n_im[10] = st;  n_re[15] = ct; n_im[15] = -st;
            end
            G_RZX: begin
                n_re[0] = ct;   n_im[1] = -st; n_im[4] = -st; n_re[5] = ct;
                n_re[10] = ct;  n_im[11] = st; n_im[14] = st; n_re[15] = ct;
            end
            G_XMY: begin
                n_re[0] = ct; n_re[3] = -n_m[1]; n_im[3] = -n_m[0];
                n_re[5] = Q_ONE; n_re[10] = Q_ONE;
                n_re[12] = n_m[1]; n_im[12] = -n_m[0]; n_re[15] = ct;
            end
            G_XPY: begin
                n_re[0] = Q_ONE; n_re[5] = ct; n_re[6] = n_m[1]; n_im[6] = -n_m[0];
                n_re[9] = -n_m[1]; n_im[9] = -n_m[0]; n_re[10] = ct; n_re[15] = Q_ONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl.valid <= 1'b0;
            r_a_ctl.valid <= 1'b0;
            r_c_ctl.valid <= 1'b0;
        end else if (i_en) begin
            // multiply
            r_m_ctl   <= i_ctl;
            r_m_ct    <= i_cos[0];
            r_m_st    <= i_sin[0];
            r_m_c1    <= i_cos[1];
            r_m_s1    <= i_sin[1];
            r_prod[0] <= 32'(i_cos[1]) * n_k;
            r_prod[1] <= 32'(i_sin[1]) * n_k;
            r_prod[2] <= 32'(i_cos[2]) * n_k;
            r_prod[3] <= 32'(i_sin[2]) * n_k;
            r_prod[4] <= 32'(i_cos[3]) * n_k2;
            r_prod[5] <= 32'(i_sin[3]) * n_k2;
            // place
            r_a_ctl <= r_m_ctl;
            r_a_re  <= n_re;
            r_a_im  <= n_im;
            // round and saturate
            r_c_ctl <= r_a_ctl;
            for (int k = 0; k < 16; k++) begin
                r_c_re[k] <= to_coef(r_a_re[k]);
                r_c_im[k] <= to_coef(r_a_im[k]);
            end
        end
    end

    assign o_ctl = r_c_ctl;
    assign o_re  = r_c_re;
    assign o_im  = r_c_im;

endmodule
`default_nettype wire

/* hdl/qgmg_serial.sv */
// Entry serialiser: holds one finished matrix and sends it one beat per entry.
// Depends on qgmg_pkg.
`default_nettype none
module qgmg_serial (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire qgmg_pkg::t_ctl  i_ctl,
    input  wire qgmg_pkg::t_coef i_re [16],
    input  wire qgmg_pkg::t_coef i_im [16],
    output logic                 o_take,
    output logic                 o_tvalid,
    input  wire logic            i_tready,
    output logic [1:0]           o_row,
    output logic [1:0]           o_col,
    output qgmg_pkg::t_coef      o_re,
    output qgmg_pkg::t_coef      o_im,
    output logic                 o_last,
    output logic                 o_bad
);
    import qgmg_pkg::*;

    logic       r_active;
    logic [3:0] r_idx;
    logic       r_dim4;
    logic       r_bad;
    t_coef      r_re [16];
    t_coef      r_im [16];
    logic       n_beat;
    logic       n_end;
    logic       n_last;

    // last entry of this matrix
    always_comb begin
        if (r_bad) begin
            n_last = 1'b1;
        end else if (r_dim4) begin
            n_last = (r_idx == 4'd15);
        end else begin
            n_last = (r_idx == 4'd3);
        end
    end

    assign n_beat = r_active && i_tready;
    assign n_end  = n_beat && n_last;
    assign o_take = !r_active || n_end;

    // load a new matrix, or step through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (i_ctl.valid && o_take) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_dim4   <= (i_ctl.gate >= G_FIRST_TWO) && (i_ctl.gate <= G_LAST);
            r_bad    <= (i_ctl.gate > G_LAST);
            r_re     <= i_re;
            r_im     <= i_im;
        end else if (n_end) begin
            r_active <= 1'b0;
        end else if (n_beat) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    assign o_tvalid = r_active;
    assign o_row    = r_dim4 ? r_idx[3:2] : {1'b0, r_idx[1]};
    assign o_col    = r_dim4 ? r_idx[1:0] : {1'b0, r_idx[0]};
    assign o_re     = r_re[r_idx];
    assign o_im     = r_im[r_idx];
    assign o_last   = n_last;
    assign o_bad    = r_bad;

endmodule
`default_nettype wire

/* hdl/quantum_gate_matrix_generator_unit.sv */
// Quantum gate matrix generator: a gate code and angles in, matrix entries out.
// Depends on qgmg_pkg, qgmg_cordic, qgmg_matrix and qgmg_serial.
//
// One beat on the input carries a gate code and three angles; the block answers
// with the gate's unitary in row-major order, one entry a beat: four beats for a
// single-qubit gate, sixteen for a two-qubit gate, and one flagged beat for an
// unknown code. The first entry passes one phase stage, 24 CORDIC stages and the
// quadrant, multiply, placement and rounding registers before the serialiser. The
// sustained rate is set by the output serialiser, which sends one entry a cycle
// while the sink is ready and loads the next matrix as the last entry goes out;
// the next input is taken while the previous matrix is still being sent.
`default_nettype none
module quantum_gate_matrix_generator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [qgmg_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // angle_a, angle_b, angle_c
    input  wire logic [5:0]                        i_s_axis_tuser,  // gate_code
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [qgmg_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,  // row, col, real, imag
    output logic                                   o_m_axis_tlast,
    output logic                                   o_m_axis_tuser   // bad_gate
);
    import qgmg_pkg::*;

    logic   n_en;
    logic   n_take;
    t_ctl   n_in_ctl;
    t_phase n_ph [4];
    t_phase n_a;
    t_phase n_b;
    t_phase n_c;
    t_gate  n_g;
    t_ctl   n_cor_ctl;
    t_q     n_cos [4];
    t_q     n_sin [4];
    t_ctl   n_mat_ctl;
    t_coef  n_re [16];
    t_coef  n_im [16];
    logic [1:0] n_row;
    logic [1:0] n_col;
    t_coef  n_ore;
    t_coef  n_oim;

    // advance the pipe unless a finished matrix waits for the serialiser
    assign n_en            = !n_mat_ctl.valid || n_take;
    assign o_s_axis_tready = n_en;

    // phases for each CORDIC lane by gate
    always_comb begin
        n_g = i_s_axis_tuser;
        n_a = angle_in(i_s_axis_tdata[31:0]);
        n_b = angle_in(i_s_axis_tdata[63:32]);
        n_c = angle_in(i_s_axis_tdata[95:64]);
        n_in_ctl.valid = i_s_axis_tvalid;
        n_in_ctl.gate  = n_g;
        n_ph[0] = n_a;
        case (n_g)
            G_U: begin
                n_ph[1] = n_c << 1;
                n_ph[2] = n_b << 1;
                n_ph[3] = (n_c + n_b) << 1;
            end
            G_U2: begin
                n_ph[1] = n_b << 1;
                n_ph[2] = n_a << 1;
                n_ph[3] = (n_b + n_a) << 1;
            end
            G_P: begin
                n_ph[1] = n_a << 1;
                n_ph[2] = n_a << 1;
                n_ph[3] = (n_a + n_b) << 1;
            end
            default: begin
                n_ph[1] = n_b << 1;
                n_ph[2] = n_a << 1;
                n_ph[3] = (n_a + n_b) << 1;
            end
        endcase
    end

    qgmg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_in_ctl),
        .i_ph    (n_ph),
        .o_ctl   (n_cor_ctl),
        .o_cos   (n_cos),
        .o_sin   (n_sin)
    );

    qgmg_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_cor_ctl),
        .i_cos   (n_cos),
        .i_sin   (n_sin),
        .o_ctl   (n_mat_ctl),
        .o_re    (n_re),
        .o_im    (n_im)
    );

    qgmg_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (n_mat_ctl),
        .i_re     (n_re),
        .i_im     (n_im),
        .o_take   (n_take),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_row    (n_row),
        .o_col    (n_col),
        .o_re     (n_ore),
        .o_im     (n_oim),
        .o_last   (o_m_axis_tlast),
        .o_bad    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({n_oim, n_ore, n_col, n_row});

endmodule
`default_nettype wire

/* hdl/qgmg_checker.sv */
// Port-level checker for the gate matrix generator, bound to the top level.
// Depends on qgmg_pkg and the assertion macro header.
`default_nettype none
`include "quantum_gate_matrix_generator_unit_macros.svh"
module qgmg_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    input  wire logic                           o_s_axis_tready,
    input  wire logic [qgmg_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic [5:0]                     i_s_axis_tuser,
    input  wire logic                           o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [qgmg_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic                           o_m_axis_tlast,
    input  wire logic                           o_m_axis_tuser
);
    logic n_stall;
    logic n_good_end;
    logic n_corner;

    // stalled beat, closing good beat and bottom-right position
    assign n_stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign n_good_end = o_m_axis_tvalid && o_m_axis_tlast && !o_m_axis_tuser;
    assign n_corner   = (o_m_axis_tdata[3:0] == 4'b0101) || (o_m_axis_tdata[3:0] == 4'b1111);

    // a stalled beat holds its data
    `QGMG_ASSERT_NXT(a_hold, n_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // a bad code gives one all-zero closing beat
    `QGMG_ASSERT_IMP(a_bad_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast && (o_m_axis_tdata == '0))
    // a good matrix closes on its bottom-right entry
    `QGMG_ASSERT_IMP(a_last_pos, n_good_end, n_corner)
    // a beat before the last never carries the bad flag
    `QGMG_ASSERT_IMP(a_bad_last, o_m_axis_tvalid && !o_m_axis_tlast, !o_m_axis_tuser)

endmodule

bind quantum_gate_matrix_generator_unit qgmg_checker u_qgmg_checker (.*);
`default_nettype wire

/* verif/tb_quantum_gate_matrix_generator_unit.sv */
// Self-checking bench for the quantum gate matrix generator unit.
// Depends on qgmg_pkg and the RTL; predicts every matrix entry in fixed point.
`timescale 1ns / 100ps
`default_nettype none
module tb_quantum_gate_matrix_generator_unit;
    import qgmg_pkg::*;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [17:0] re;
        logic [17:0] im;
        logic        last;
        logic        bad;
    } t_entry;

    typedef struct {
        t_gate       gate;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          typed;   // expected beat written in the table
    } t_stim;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 436;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_DATA_W-1:0]   s_data = '0;   // angle_a, angle_b, angle_c
    logic [5:0]             s_user = '0;   // gate_code
    logic                   s_ready;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_data;        // row, col, real, imag
    logic                   m_last;
    logic                   m_user;        // bad_gate

    t_entry entries_due[$];
    int     err_count = 0;
    int     beats_seen = 0;
    int     items_sent = 0;
    int     snd_pct = 0;
    int     rcv_pct = 0;
    int     idle_cycles = 0;

    quantum_gate_matrix_generator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Rotate a phase (a full turn being 2^32) by CORDIC, quadrant applied afterwards
    function automatic void cordic_sin_cos(input logic [31:0] ph, output longint cv,
                                           output longint sv);
        longint x, y, z, nx;
        begin
            x = Q_GAIN;
            y = 0;
            z = longint'(ph[29:0]);
            for (int i = 0; i < CORDIC_ITER; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ATAN_TAB[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ATAN_TAB[i]);
                end
                x = nx;
            end
            case (ph[31:30])
                2'd0: begin cv = x;  sv = y;  end
                2'd1: begin cv = -y; sv = x;  end
                2'd2: begin cv = -x; sv = -y; end
                default: begin cv = y; sv = -x; end
            endcase
        end
    endfunction

    function automatic longint q30_mul(input longint x, input longint y);
        return (x * y + 64'sd536870912) >>> 30;
    endfunction

    // Round Q30 to Q2.16 and saturate
    function automatic logic [17:0] q30_to_coef(input longint v);
        longint t;
        begin
            t = (v + 8192) >>> 14;
            if (t > 131071) t = 131071;
            if (t < -131072) t = -131072;
            return t[17:0];
        end
    endfunction

    // Queue the expected entries of one gate matrix
    task automatic predict_matrix(input t_gate g, input logic [31:0] a,
                                  input logic [31:0] b, input logic [31:0] c);
        longint mr[16], mi[16];
        longint ct, st, c1, s1, c2, s2, c3, s3;
        longint o, h, p;
        int dim, n;
        t_entry e;
        begin
            // unknown code: a single flagged zero entry
            if (g > G_LAST) begin
                e = '{row: 2'd0, col: 2'd0, re: 18'd0, im: 18'd0, last: 1'b1, bad: 1'b1};
                entries_due.push_back(e);
                return;
            end
            o = Q_ONE;
            h = Q_SQ;
            p = Q_HALF;
            for (int k = 0; k < 16; k++) begin
                mr[k] = 0;
                mi[k] = 0;
            end
            cordic_sin_cos(a, ct, st);
            dim = (g >= G_FIRST_TWO) ? 4 : 2;
            case (g)
                G_I:    begin mr[0] = o; mr[3] = o; end
                G_H:    begin mr[0] = h; mr[1] = h; mr[2] = h; mr[3] = -h; end
                G_X:    begin mr[1] = o; mr[2] = o; end
                G_Y:    begin mi[1] = -o; mi[2] = o; end
                G_Z:    begin mr[0] = o; mr[3] = -o; end
                G_S:    begin mr[0] = o; mi[3] = o; end
                G_SDG:  begin mr[0] = o; mi[3] = -o; end
                G_T:    begin mr[0] = o; mr[3] = h; mi[3] = h; end
                G_TDG:  begin mr[0] = o; mr[3] = h; mi[3] = -h; end
                G_SX: begin
                    mr[0] = p; mi[0] = p; mr[1] = p; mi[1] = -p;
                    mr[2] = p; mi[2] = -p; mr[3] = p; mi[3] = p;
                end
                G_SXDG: begin
                    mr[0] = p; mi[0] = -p; mr[1] = p; mi[1] = p;
                    mr[2] = p; mi[2] = p; mr[3] = p; mi[3] = -p;
                end
                G_V:    begin mr[0] = h; mi[1] = -h; mi[2] = -h; mr[3] = h; end
                G_VDG:  begin mr[0] = h; mi[1] = h; mi[2] = h; mr[3] = h; end
                G_U: begin
                    cordic_sin_cos(c << 1, c1, s1);
                    cordic_sin_cos(b << 1, c2, s2);
                    cordic_sin_cos((c + b) << 1, c3, s3);
                    mr[0] = ct;
                    mr[1] = -q30_mul(c1, st); mi[1] = -q30_mul(s1, st);
                    mr[2] = q30_mul(c2, st);  mi[2] = q30_mul(s2, st);
                    mr[3] = q30_mul(c3, ct);  mi[3] = q30_mul(s3, ct);
                end
                G_U2: begin
                    cordic_sin_cos(b << 1, c1, s1);
                    cordic_sin_cos(a << 1, c2, s2);
                    cordic_sin_cos((b + a) << 1, c3, s3);
                    mr[0] = h;
                    mr[1] = -q30_mul(c1, h); mi[1] = -q30_mul(s1, h);
                    mr[2] = q30_mul(c2, h);  mi[2] = q30_mul(s2, h);
                    mr[3] = q30_mul(c3, h);  mi[3] = q30_mul(s3, h);
                end
                G_P: begin
                    cordic_sin_cos(a << 1, c1, s1);
                    mr[0] = o; mr[3] = c1; mi[3] = s1;
                end
                G_RX:   begin mr[0] = ct; mi[1] = -st; mi[2] = -st; mr[3] = ct; end
                G_RY:   begin mr[0] = ct; mr[1] = -st; mr[2] = st; mr[3] = ct; end
                G_RZ:   begin mr[0] = ct; mi[0] = -st; mr[3] = ct; mi[3] = st; end
                G_SWAP: begin mr[0] = o; mr[6] = o; mr[9] = o; mr[15] = o; end
                G_ISW:  begin mr[0] = o; mi[6] = o; mi[9] = o; mr[15] = o; end
                G_ISWDG: begin mr[0] = o; mi[6] = -o; mi[9] = -o; mr[15] = o; end
                G_ECR: begin
                    mr[2] = h; mi[3] = h; mi[6] = h; mr[7] = h;
                    mr[8] = h; mi[9] = -h; mi[12] = -h; mr[13] = h;
                end
                G_DCX:  begin mr[0] = o; mr[6] = o; mr[11] = o; mr[13] = o; end
                G_PER:  begin mr[3] = o; mr[6] = o; mr[8] = o; mr[13] = o; end
                G_PERDG: begin mr[2] = o; mr[7] = o; mr[9] = o; mr[12] = o; end
                G_RXX: begin
                    mr[0] = ct; mi[3] = -st; mr[5] = ct; mi[6] = -st;
                    mi[9] = -st; mr[10] = ct; mi[12] = -st; mr[15] = ct;
                end
                G_RYY: begin
                    mr[0] = ct; mi[3] = st; mr[5] = ct; mi[6] = -st;
                    mi[9] = -st; mr[10] = ct; mi[12] = st; mr[15] = ct;
                end
                G_RZZ: begin
                    mr[0] = ct; mi[0] = -st; mr[5] = ct; mi[5] = st;
                    mr[10] = ct; mi[10] = st; mr[15] = ct; mi[15] = -st;
                end
                G_RZX: begin
                    mr[0] = ct; mi[1] = -st; mi[4] = -st; mr[5] = ct;
                    mr[10] = ct; mi[11] = st; mi[14] = st; mr[15] = ct;
                end
                G_XMY: begin
                    cordic_sin_cos(b << 1, c1, s1);
                    mr[0] = ct;
                    mr[3] = -q30_mul(s1, st); mi[3] = -q30_mul(c1, st);
                    mr[5] = o; mr[10] = o;
                    mr[12] = q30_mul(s1, st); mi[12] = -q30_mul(c1, st);
                    mr[15] = ct;
                end
                default: begin
                    cordic_sin_cos(b << 1, c1, s1);
                    mr[0] = o; mr[5] = ct;
                    mr[6] = q30_mul(s1, st); mi[6] = -q30_mul(c1, st);
                    mr[9] = -q30_mul(s1, st); mi[9] = -q30_mul(c1, st);
                    mr[10] = ct; mr[15] = o;
                end
            endcase
            n = dim * dim;
            for (int k = 0; k < n; k++) begin
                e.row  = 2'(k / dim);
                e.col  = 2'(k % dim);
                e.re   = q30_to_coef(mr[k]);
                e.im   = q30_to_coef(mi[k]);
                e.last = (k == n - 1);
                e.bad  = 1'b0;
                entries_due.push_back(e);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Offer one beat, hold it until taken, then queue its expectation
    task automatic send_item(input t_stim st);
        t_entry e;
        begin
            while ($urandom_range(99) < snd_pct) begin
                s_valid = 1'b0;
                @(negedge i_clk);
            end
            s_valid = 1'b1;
            s_data  = {st.c, st.b, st.a};
            s_user  = st.gate;
            do @(posedge i_clk); while (!s_ready);
            if (st.typed) begin
                // unknown code typed in: a single flagged zero entry
                e = '{row: 2'd0, col: 2'd0, re: 18'd0, im: 18'd0, last: 1'b1, bad: 1'b1};
                entries_due.push_back(e);
            end else begin
                predict_matrix(st.gate, st.a, st.b, st.c);
            end
            items_sent++;
            @(negedge i_clk);
            s_valid = 1'b0;
        end
    endtask

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return {2'($urandom_range(3)), 30'h0};   // exact quadrant boundary
            default: return $urandom;
        endcase
    endfunction

    // Receiver stalls, redrawn each cycle
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= rcv_pct);
    end

    // Check each output beat against the oldest expected entry
    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && m_valid && m_ready) begin
            beats_seen++;
            if (entries_due.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                e = entries_due.pop_front();
                if (m_data[1:0] !== e.row) report_mismatch("row", m_data[1:0], e.row);
                if (m_data[3:2] !== e.col) report_mismatch("col", m_data[3:2], e.col);
                if (m_data[21:4] !== e.re)
                    report_mismatch("real", $signed(m_data[21:4]), $signed(e.re));
                if (m_data[39:22] !== e.im)
                    report_mismatch("imag", $signed(m_data[39:22]), $signed(e.im));
                if (m_last !== e.last) report_mismatch("last", m_last, e.last);
                if (m_user !== e.bad) report_mismatch("bad_gate", m_user, e.bad);
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        t_stim directed [] = '{
            '{G_I,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_H,     32'h7fffffff,  32'h80000000,  32'hffffffff,  1'b0},
            '{G_X,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_Y,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_Z,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_S,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_SDG,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_T,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_TDG,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_SX,    32'h0,         32'h0,         32'h0,         1'b0},
            '{G_SXDG,  32'h0,         32'h0,         32'h0,         1'b0},
            '{G_V,     32'h0,         32'h0,         32'h0,         1'b0},
            '{G_VDG,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_U,     32'h7fffffff,  32'h80000000,  32'h7fffffff,  1'b0},
            '{G_U2,    32'h80000000,  32'h80000000,  32'h0,         1'b0},
            '{G_P,     32'h40000000,  32'h0,         32'h0,         1'b0},
            '{G_RX,    32'h80000000,  32'h0,         32'h0,         1'b0},
            '{G_RY,    32'hffffffff,  32'h0,         32'h0,         1'b0},
            '{G_RZ,    32'h7fffffff,  32'h0,         32'h0,         1'b0},
            '{G_SWAP,  32'h0,         32'h0,         32'h0,         1'b0},
            '{G_ISW,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_ISWDG, 32'h0,         32'h0,         32'h0,         1'b0},
            '{G_ECR,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_DCX,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_PER,   32'h0,         32'h0,         32'h0,         1'b0},
            '{G_PERDG, 32'h0,         32'h0,         32'h0,         1'b0},
            '{G_RXX,   32'h20000000,  32'h0,         32'h0,         1'b0},
            '{G_RYY,   32'hc0000000,  32'h0,         32'h0,         1'b0},
            '{G_RZZ,   32'h80000000,  32'h0,         32'h0,         1'b0},
            '{G_RZX,   32'h7fffffff,  32'h0,         32'h0,         1'b0},
            '{G_XMY,   32'h80000000,  32'h7fffffff,  32'h0,         1'b0},
            '{G_XPY,   32'h7fffffff,  32'h80000000,  32'h0,         1'b0},
            '{6'd32,   32'h0,         32'h0,         32'h0,         1'b1},
            '{6'd63,   32'hffffffff,  32'hffffffff,  32'hffffffff,  1'b1}
        };
        t_stim st;
        int wait_cycles;

        // Hold reset, then release it at a falling clock edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (directed[i]) send_item(directed[i]);

        // Random items in four idling phases, draining fully before each
        for (int ph = 0; ph < 4; ph++) begin
            while (entries_due.size() != 0) @(negedge i_clk);
            case (ph)
                0: begin snd_pct = 0;  rcv_pct = 0;  end
                1: begin snd_pct = 59; rcv_pct = 0;  end
                2: begin snd_pct = 0;  rcv_pct = 59; end
                default: begin snd_pct = 22; rcv_pct = 22; end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
                // mostly valid gates, some unknown codes
                st.gate  = ($urandom_range(9) == 0) ? t_gate'($urandom_range(63, 32))
                                                     : t_gate'($urandom_range(31));
                st.a     = pick_angle();
                st.b     = pick_angle();
                st.c     = pick_angle();
                st.typed = 1'b0;
                send_item(st);
            end
        end

        // Wait for every entry, then let the pipeline settle
        wait_cycles = 0;
        while (entries_due.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items (all 32 gates, unknown codes, angle extremes)", items_sent);
        $display("checked %0d matrix entries under four idling patterns", beats_seen);
        if (err_count == 0 && entries_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
